/* design/mlp_backprop_online_trainer_unit_defines.svh */
// Assertion macros used by the checker file mlp_bp_chk.sv.
`ifndef MLP_BACKPROP_ONLINE_TRAINER_UNIT_DEFINES_SVH
`define MLP_BACKPROP_ONLINE_TRAINER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MBP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/mlp_bp_pkg.sv */
`default_nettype none
package mlp_bp_pkg;

  localparam int NUM_FEATURES    = 3;
  localparam int NUM_HIDDEN      = 2;
  localparam int FRAC_BITS       = 12;
  localparam int SIGMOID_ENTRIES = 256;

  localparam int HID_ROW   = NUM_FEATURES + 1;
  localparam int HID_COUNT = NUM_HIDDEN * HID_ROW;
  localparam int OUT_COUNT = NUM_HIDDEN + 1;
  localparam int W_COUNT   = HID_COUNT + OUT_COUNT;
  localparam int WIDX_W    = $clog2(W_COUNT);
  localparam int I_W       = $clog2(HID_ROW);
  localparam int J_W       = $clog2(OUT_COUNT);

  localparam int ONE       = 1 << FRAC_BITS;
  localparam int ACC_W     = 34;
  localparam int A_W       = 40;
  localparam int B_W       = 18;
  localparam int P_W       = A_W + B_W;
  localparam int SIG_SHIFT = 4 + 2 * FRAC_BITS - $clog2(SIGMOID_ENTRIES);
  localparam int SIG_AW    = $clog2(SIGMOID_ENTRIES);

  localparam logic [12:0] LR_RESET  = 13'd410;
  localparam logic [12:0] THR_RESET = 13'd2048;

  localparam logic REG_LR  = 1'b0;
  localparam logic REG_THR = 1'b1;

  typedef enum logic [1:0] {
    CMD_TRAIN = 2'd0,
    CMD_INFER = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HID, S_OUT, S_ERR, S_DO1, S_DO2, S_DH1, S_DH2, S_DH3,
    S_UO1, S_UO2, S_UH1, S_UH2, S_DONE
  } state_t;

  typedef logic [12:0] sig_rom_t [SIGMOID_ENTRIES];

  // Restoring long division, used only while the ROM contents are built.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned dv);
    longint unsigned q;
    longint unsigned rem;
    q = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], n[k]};
      if (rem >= dv) begin
        rem = rem - dv;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid at the midpoint of interval k, evaluated at elaboration only.
  function automatic logic [12:0] sig_rom_entry(input int k);
    longint num;
    longint sum;
    longint unsigned a, den, b, term, e, d, q30, r;
    int i;
    q30 = 64'd1 << 30;
    num = 8 * (2 * k + 1) - 8 * SIGMOID_ENTRIES;
    a = (num < 0) ? longint'(-num) : longint'(num);
    den = 64 * SIGMOID_ENTRIES;
    b = udiv64((a << 30) + den / 2, den);
    term = q30;
    sum = q30;
    for (i = 1; i <= 12; i++) begin
      term = udiv64((term * b + (q30 >> 1)) >> 30, 64'(i));
      if (i % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    e = (sum > 0) ? longint'(sum) : 64'd0;
    for (i = 0; i < 6; i++) begin
      e = (e * e + (q30 >> 1)) >> 30;
    end
    d = q30 + e;
    if (num >= 0) r = udiv64((longint'(ONE) << 30) + d / 2, d);
    else r = udiv64(longint'(ONE) * e + d / 2, d);
    return r[12:0];
  endfunction

  function automatic sig_rom_t sig_rom_init();
    sig_rom_t t;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
      t[k] = sig_rom_entry(k);
    end
    return t;
  endfunction

  localparam sig_rom_t SIG_ROM = sig_rom_init();

  // Sum carries 2*FRAC_BITS fraction bits.
  function automatic logic [12:0] sig_lookup(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W:0] v;
    logic signed [ACC_W:0] q;
    v = (ACC_W+1)'(s) + ((ACC_W+1)'(8) <<< (2 * FRAC_BITS));
    q = v >>> SIG_SHIFT;
    if (v < 0) return SIG_ROM[0];
    else if (q > SIGMOID_ENTRIES - 1) return SIG_ROM[SIGMOID_ENTRIES-1];
    else return SIG_ROM[q[SIG_AW-1:0]];
  endfunction

endpackage
`default_nettype wire

/* design/mlp_backprop_online_trainer_unit.sv */
`default_nettype none
// Online trainer for a 3-2-1 sigmoid perceptron in Q3.12. An item is taken when start
// is high and busy is low; its result appears for exactly one cycle with done high, and
// the receiver cannot stall it. The result of a load or unused command appears the cycle
// after the item is taken; an infer first steps through S_HID and S_OUT, and a train
// goes on through S_ERR, the delta states and the update states. Busy falls the cycle
// after the result, and no new item is taken while busy is high. Each product goes through
// one shared multiplier, registered and used while ph is high. Weights reset to zero.
module mlp_backprop_online_trainer_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd,
  input  wire logic [12:0]        feature_a,
  input  wire logic [12:0]        feature_b,
  input  wire logic [12:0]        feature_c,
  input  wire logic [12:0]        target,
  input  wire logic [3:0]         weight_index,
  input  wire logic signed [15:0] weight_value,
  output logic                    done,
  output logic [12:0]             prediction,
  output logic                    decision,
  output logic [11:0]             sample_error,
  output logic                    saturated,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int HR = mlp_bp_pkg::HID_ROW;
  localparam int NH = mlp_bp_pkg::NUM_HIDDEN;
  localparam int OC = mlp_bp_pkg::OUT_COUNT;
  localparam int HC = mlp_bp_pkg::HID_COUNT;
  localparam int PW = mlp_bp_pkg::P_W;
  localparam int AW = mlp_bp_pkg::A_W;
  localparam int BW = mlp_bp_pkg::B_W;
  localparam int ACW = mlp_bp_pkg::ACC_W;
  localparam logic [12:0] ONE13 = 13'(mlp_bp_pkg::ONE);

  mlp_bp_pkg::state_t state, state_next;
  logic ph;
  logic [mlp_bp_pkg::I_W-1:0] i;
  logic [mlp_bp_pkg::J_W-1:0] j;
  mlp_bp_pkg::cmd_t cmd_r;
  logic [12:0] x [HR];
  logic [12:0] y [OC];
  logic signed [15:0] dh [OC];
  logic [12:0] t_r, z, lr_reg, thr_reg;
  logic signed [ACW-1:0] acc;
  logic signed [AW-1:0] tmp;
  logic signed [12:0] d_o;
  logic [11:0] err;
  logic sat;
  logic signed [15:0] w [mlp_bp_pkg::W_COUNT];

  logic signed [AW-1:0] op_a;
  logic signed [BW-1:0] op_b;
  logic signed [PW-1:0] prod;
  logic [mlp_bp_pkg::WIDX_W-1:0] widx, hidx;
  logic signed [15:0] wsel;
  logic signed [13:0] e;
  logic [12:0] lr_c, one_m_z, one_m_y;
  logic signed [ACW-1:0] acc_sum;
  logic signed [PW-1:0] r24;
  logic signed [17:0] usum;
  logic signed [15:0] wnew;
  logic clip, accept, last_i, last_hj, last_oj, cfg_wr;

  mlp_bp_mac u_mac (.clk(clk), .a(op_a), .b(op_b), .prod(prod));

  function automatic logic [12:0] clamp1(input logic [12:0] v);
    return (v > ONE13) ? ONE13 : v;
  endfunction

  assign accept  = start && !busy;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == mlp_bp_pkg::REG_THR) ? {19'd0, thr_reg} : {19'd0, lr_reg};
  assign last_i  = (i == mlp_bp_pkg::I_W'(HR - 1));
  assign last_hj = (j == mlp_bp_pkg::J_W'(NH - 1));
  assign last_oj = (j == mlp_bp_pkg::J_W'(OC - 1));
  assign lr_c    = clamp1(lr_reg);
  assign e       = $signed({1'b0, t_r}) - $signed({1'b0, z});
  assign one_m_z = ONE13 - z;
  assign one_m_y = ONE13 - y[j];
  assign hidx    = mlp_bp_pkg::WIDX_W'(j) * mlp_bp_pkg::WIDX_W'(HR) + mlp_bp_pkg::WIDX_W'(i);

  // Operand selection and the weight read port.
  always_comb begin
    op_a = '0;
    op_b = '0;
    widx = hidx;
    case (state)
      mlp_bp_pkg::S_HID: begin
        op_a = AW'($signed({1'b0, x[i]}));
        op_b = BW'(w[hidx]);
      end
      mlp_bp_pkg::S_OUT, mlp_bp_pkg::S_UO2: begin
        widx = mlp_bp_pkg::WIDX_W'(HC) + mlp_bp_pkg::WIDX_W'(j);
        op_a = (state == mlp_bp_pkg::S_OUT) ? AW'($signed({1'b0, y[j]})) : tmp;
        op_b = (state == mlp_bp_pkg::S_OUT) ? BW'(w[widx]) : BW'($signed({1'b0, y[j]}));
      end
      mlp_bp_pkg::S_ERR: begin
        op_a = AW'(e);
        op_b = BW'(e);
      end
      mlp_bp_pkg::S_DO1: begin
        op_a = AW'(e);
        op_b = BW'($signed({1'b0, z}));
      end
      mlp_bp_pkg::S_DO2: begin
        op_a = tmp;
        op_b = BW'($signed({1'b0, one_m_z}));
      end
      mlp_bp_pkg::S_DH1: begin
        op_a = AW'($signed({1'b0, y[j]}));
        op_b = BW'($signed({1'b0, one_m_y}));
      end
      mlp_bp_pkg::S_DH2: begin
        op_a = tmp;
        op_b = BW'(d_o);
      end
      mlp_bp_pkg::S_DH3: begin
        widx = mlp_bp_pkg::WIDX_W'(HC) + mlp_bp_pkg::WIDX_W'(j);
        op_a = tmp;
        op_b = BW'(w[widx]);
      end
      mlp_bp_pkg::S_UO1: begin
        op_a = AW'($signed({1'b0, lr_c}));
        op_b = BW'(d_o);
      end
      mlp_bp_pkg::S_UH1: begin
        op_a = AW'($signed({1'b0, lr_c}));
        op_b = BW'(dh[j]);
      end
      mlp_bp_pkg::S_UH2: begin
        op_a = tmp;
        op_b = BW'($signed({1'b0, x[i]}));
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // Update arithmetic on the registered product.
  always_comb begin
    wsel    = w[widx];
    acc_sum = acc + ACW'(prod);
    r24     = (prod + (PW'(1) <<< (2 * mlp_bp_pkg::FRAC_BITS - 1))) >>>
              (2 * mlp_bp_pkg::FRAC_BITS);
    usum    = 18'(wsel) + 18'(r24);
    clip    = (usum > 18'sd32767) || (usum < -18'sd32768);
    if (usum > 18'sd32767) wnew = 16'sd32767;
    else if (usum < -18'sd32768) wnew = -16'sd32768;
    else wnew = usum[15:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      mlp_bp_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd == mlp_bp_pkg::CMD_TRAIN || cmd == mlp_bp_pkg::CMD_INFER)
            state_next = mlp_bp_pkg::S_HID;
          else
            state_next = mlp_bp_pkg::S_DONE;
        end
      end
      mlp_bp_pkg::S_HID: if (ph && last_i && last_hj) state_next = mlp_bp_pkg::S_OUT;
      mlp_bp_pkg::S_OUT: begin
        if (ph && last_oj)
          state_next = (cmd_r == mlp_bp_pkg::CMD_INFER) ? mlp_bp_pkg::S_DONE
                                                        : mlp_bp_pkg::S_ERR;
      end
      mlp_bp_pkg::S_ERR: if (ph) state_next = mlp_bp_pkg::S_DO1;
      mlp_bp_pkg::S_DO1: if (ph) state_next = mlp_bp_pkg::S_DO2;
      mlp_bp_pkg::S_DO2: if (ph) state_next = mlp_bp_pkg::S_DH1;
      mlp_bp_pkg::S_DH1: if (ph) state_next = mlp_bp_pkg::S_DH2;
      mlp_bp_pkg::S_DH2: if (ph) state_next = mlp_bp_pkg::S_DH3;
      mlp_bp_pkg::S_DH3: begin
        if (ph) state_next = last_hj ? mlp_bp_pkg::S_UO1 : mlp_bp_pkg::S_DH1;
      end
      mlp_bp_pkg::S_UO1: if (ph) state_next = mlp_bp_pkg::S_UO2;
      mlp_bp_pkg::S_UO2: if (ph && last_oj) state_next = mlp_bp_pkg::S_UH1;
      mlp_bp_pkg::S_UH1: if (ph) state_next = mlp_bp_pkg::S_UH2;
      mlp_bp_pkg::S_UH2: begin
        if (ph && last_i) state_next = last_hj ? mlp_bp_pkg::S_DONE : mlp_bp_pkg::S_UH1;
      end
      mlp_bp_pkg::S_DONE: state_next = mlp_bp_pkg::S_IDLE;
      default: state_next = mlp_bp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != mlp_bp_pkg::S_IDLE);
    done = (state == mlp_bp_pkg::S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mlp_bp_pkg::S_IDLE;
      ph      <= 1'b0;
      i       <= '0;
      j       <= '0;
      lr_reg  <= mlp_bp_pkg::LR_RESET;
      thr_reg <= mlp_bp_pkg::THR_RESET;
      for (int k = 0; k < mlp_bp_pkg::W_COUNT; k++) w[k] <= '0;
    end else begin
      state <= state_next;
      ph    <= (state == mlp_bp_pkg::S_IDLE || state == mlp_bp_pkg::S_DONE) ? 1'b0 : !ph;
      if (cfg_wr) begin
        if (paddr[2] == mlp_bp_pkg::REG_LR) lr_reg <= pwdata[12:0];
        else thr_reg <= pwdata[12:0];
      end
      if (accept) begin
        i <= '0;
        j <= '0;
        if (cmd == mlp_bp_pkg::CMD_LOAD && weight_index < 4'(mlp_bp_pkg::W_COUNT))
          w[weight_index[mlp_bp_pkg::WIDX_W-1:0]] <= weight_value;
      end else if (ph) begin
        case (state)
          mlp_bp_pkg::S_HID, mlp_bp_pkg::S_UH2: begin
            if (state == mlp_bp_pkg::S_UH2) w[widx] <= wnew;
            if (last_i) begin
              i <= '0;
              j <= last_hj ? '0 : j + 1'b1;
            end else begin
              i <= i + 1'b1;
            end
          end
          mlp_bp_pkg::S_OUT: j <= last_oj ? '0 : j + 1'b1;
          mlp_bp_pkg::S_UO2: begin
            w[widx] <= wnew;
            j <= last_oj ? '0 : j + 1'b1;
          end
          mlp_bp_pkg::S_DH3: j <= last_hj ? '0 : j + 1'b1;
          default: i <= i;
        endcase
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= mlp_bp_pkg::cmd_t'(cmd);
      x[0]  <= clamp1(feature_a);
      x[1]  <= clamp1(feature_b);
      x[2]  <= clamp1(feature_c);
      for (int k = 3; k < HR - 1; k++) x[k] <= '0;
      x[HR-1] <= ONE13;
      y[OC-1] <= ONE13;
      t_r <= clamp1(target);
      acc <= '0;
      z   <= '0;
      err <= '0;
      sat <= 1'b0;
    end else if (ph) begin
      case (state)
        mlp_bp_pkg::S_HID: begin
          if (last_i) begin
            y[j] <= mlp_bp_pkg::sig_lookup(acc_sum);
            acc  <= '0;
          end else begin
            acc <= acc_sum;
          end
        end
        mlp_bp_pkg::S_OUT: begin
          if (last_oj) begin
            z   <= mlp_bp_pkg::sig_lookup(acc_sum);
            acc <= '0;
          end else begin
            acc <= acc_sum;
          end
        end
        mlp_bp_pkg::S_ERR: begin
          err <= 12'((prod + (PW'(1) <<< mlp_bp_pkg::FRAC_BITS)) >>>
                     (mlp_bp_pkg::FRAC_BITS + 1));
        end
        mlp_bp_pkg::S_DO1, mlp_bp_pkg::S_DH1, mlp_bp_pkg::S_DH2, mlp_bp_pkg::S_UO1,
        mlp_bp_pkg::S_UH1: tmp <= AW'(prod);
        mlp_bp_pkg::S_DO2: d_o <= 13'(r24);
        mlp_bp_pkg::S_DH3: begin
          dh[j] <= 16'((prod + (PW'(1) <<< (3 * mlp_bp_pkg::FRAC_BITS - 1))) >>>
                       (3 * mlp_bp_pkg::FRAC_BITS));
        end
        mlp_bp_pkg::S_UO2, mlp_bp_pkg::S_UH2: if (clip) sat <= 1'b1;
        default: tmp <= tmp;
      endcase
    end
  end

  // The result registers follow the command that produced them.
  always_comb begin
    prediction   = '0;
    decision     = 1'b0;
    sample_error = '0;
    saturated    = 1'b0;
    if (cmd_r == mlp_bp_pkg::CMD_TRAIN || cmd_r == mlp_bp_pkg::CMD_INFER) begin
      prediction = z;
      decision   = (z >= thr_reg);
    end
    if (cmd_r == mlp_bp_pkg::CMD_TRAIN) begin
      sample_error = err;
      saturated    = sat;
    end
  end

endmodule
`default_nettype wire

/* design/mlp_bp_mac.sv */
`default_nettype none
// Shared signed multiplier with a registered product.
module mlp_bp_mac (
  input  wire logic                                  clk,
  input  wire logic signed [mlp_bp_pkg::A_W-1:0]     a,
  input  wire logic signed [mlp_bp_pkg::B_W-1:0]     b,
  output logic signed      [mlp_bp_pkg::P_W-1:0]     prod
);

  always_ff @(posedge clk) begin
    prod <= mlp_bp_pkg::P_W'(a) * mlp_bp_pkg::P_W'(b);
  end

endmodule
`default_nettype wire

/* design/mlp_bp_chk.sv */
`default_nettype none
`include "mlp_backprop_online_trainer_unit_defines.svh"
module mlp_bp_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic [11:0] sample_error
);

  `MBP_ASSERT_NEXT(a_take_busy, clk, rst, start && !busy, busy)
  `MBP_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy)
  `MBP_ASSERT_NOW(a_done_busy, clk, rst, done, busy)
  `MBP_ASSERT_NOW(a_err_range, clk, rst, done, sample_error <= 12'd2048)

endmodule

bind mlp_backprop_online_trainer_unit mlp_bp_chk u_chk (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .sample_error(sample_error)
);
`default_nettype wire

/* verif/tb_mlp_backprop_online_trainer_unit.sv */
`timescale 1ns / 100ps
module tb_mlp_backprop_online_trainer_unit;
  import mlp_bp_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    cmd_t             op;
    logic [12:0]      fa, fb, fc, tgt;
    logic [3:0]       widx;
    logic signed [15:0] wval;
  } sample_t;

  typedef struct {
    logic [12:0] pred;
    logic        dec;
    logic [11:0] err;
    logic        sat;
  } outcome_t;

  class trainer_scoreboard;
    longint hid_w[HID_COUNT];
    longint out_w[OUT_COUNT];
    longint rate, thresh;
    longint sig_table[SIGMOID_ENTRIES];
    outcome_t pending[$];
    int mismatches;

    function void init();
      longint num, sum;
      longint unsigned a, den, b, term, e, d, q30;
      q30 = 64'd1 << 30;
      for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
        num = 8 * (2 * k + 1) - 8 * SIGMOID_ENTRIES;
        a = (num < 0) ? -num : num;
        den = 64 * SIGMOID_ENTRIES;
        b = ((a << 30) + den / 2) / den;
        term = q30;
        sum = q30;
        for (int i = 1; i <= 12; i++) begin
          term = ((term * b + (q30 >> 1)) >> 30) / i;
          if (i % 2 == 1) sum -= longint'(term);
          else sum += longint'(term);
        end
        e = (sum > 0) ? sum : 0;
        for (int i = 0; i < 6; i++) e = (e * e + (q30 >> 1)) >> 30;
        d = q30 + e;
        if (num >= 0) sig_table[k] = ((longint'(ONE) << 30) + d / 2) / d;
        else sig_table[k] = (longint'(ONE) * e + d / 2) / d;
      end
      foreach (hid_w[i]) hid_w[i] = 0;
      foreach (out_w[i]) out_w[i] = 0;
      rate = 410;
      thresh = 2048;
      mismatches = 0;
    endfunction

    function longint activate(longint s);
      longint v, idx;
      v = s + (longint'(8) << (2 * FRAC_BITS));
      idx = (v < 0) ? 0 : (v >>> 20);
      if (idx > SIGMOID_ENTRIES - 1) idx = SIGMOID_ENTRIES - 1;
      return sig_table[idx];
    endfunction

    function longint rnd(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip_one(logic [12:0] v);
      return (v > ONE) ? ONE : v;
    endfunction

    function longint clip16(longint v, inout bit flag);
      if (v > 32767) begin
        flag = 1;
        return 32767;
      end
      if (v < -32768) begin
        flag = 1;
        return -32768;
      end
      return v;
    endfunction

    function void note(sample_t s);
      outcome_t r;
      longint x[HID_ROW], y[OUT_COUNT], dh[NUM_HIDDEN];
      longint acc, z, t, e, d_o, lr;
      bit flag;
      r = '{default: 0};
      flag = 0;
      if (s.op == CMD_LOAD) begin
        if (s.widx < HID_COUNT) hid_w[s.widx] = s.wval;
        else if (s.widx < W_COUNT) out_w[s.widx - HID_COUNT] = s.wval;
      end else if (s.op != CMD_NONE) begin
        x[0] = clip_one(s.fa);
        x[1] = clip_one(s.fb);
        x[2] = clip_one(s.fc);
        x[3] = ONE;
        for (int j = 0; j < NUM_HIDDEN; j++) begin
          acc = 0;
          for (int i = 0; i < HID_ROW; i++) acc += x[i] * hid_w[j * HID_ROW + i];
          y[j] = activate(acc);
        end
        y[NUM_HIDDEN] = ONE;
        acc = 0;
        for (int j = 0; j < OUT_COUNT; j++) acc += y[j] * out_w[j];
        z = activate(acc);
        r.pred = z[12:0];
        r.dec = (z >= thresh);
        if (s.op == CMD_TRAIN) begin
          t = clip_one(s.tgt);
          lr = (rate > ONE) ? ONE : rate;
          e = t - z;
          d_o = rnd(e * z * (ONE - z), 2 * FRAC_BITS);
          // Hidden deltas use the output weights from before this update.
          for (int j = 0; j < NUM_HIDDEN; j++)
            dh[j] = rnd(y[j] * (ONE - y[j]) * d_o * out_w[j], 3 * FRAC_BITS);
          for (int j = 0; j < OUT_COUNT; j++)
            out_w[j] = clip16(out_w[j] + rnd(lr * d_o * y[j], 2 * FRAC_BITS), flag);
          for (int j = 0; j < NUM_HIDDEN; j++)
            for (int i = 0; i < HID_ROW; i++)
              hid_w[j * HID_ROW + i] = clip16(hid_w[j * HID_ROW + i]
                + rnd(lr * dh[j] * x[i], 2 * FRAC_BITS), flag);
          acc = rnd(e * e, FRAC_BITS + 1);
          r.err = acc[11:0];
          r.sat = flag;
        end
      end
      pending.push_back(r);
    endfunction

    function void check(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: pred=%0d", got.pred);
        return;
      end
      want = pending.pop_front();
      if (got.pred !== want.pred || got.dec !== want.dec ||
          got.err !== want.err || got.sat !== want.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: pred %0d/%0d dec %0b/%0b err %0d/%0d sat %0b/%0b (exp/act)",
                   want.pred, got.pred, want.dec, got.dec, want.err, got.err,
                   want.sat, got.sat);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] cmd = 0;
  logic [12:0] feature_a = 0, feature_b = 0, feature_c = 0, target = 0;
  logic [3:0] weight_index = 0;
  logic signed [15:0] weight_value = 0;
  logic done;
  logic [12:0] prediction;
  logic decision;
  logic [11:0] sample_error;
  logic saturated;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  trainer_scoreboard sb;
  int cycles = 0;
  int idle_pct = 0;

  mlp_backprop_online_trainer_unit u_top (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        sb.note('{cmd_t'(cmd), feature_a, feature_b, feature_c, target,
                  weight_index, weight_value});
      if (done) sb.check('{prediction, decision, sample_error, saturated});
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [12:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= {19'd0, val};
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == 3'd0) sb.rate = val;
    else if (addr == 3'd4) sb.thresh = val;
  endtask

  // Waits for every result, then for the unit to settle before touching registers.
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send(input sample_t s);
    logic held;
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    cmd <= s.op;
    feature_a <= s.fa;
    feature_b <= s.fb;
    feature_c <= s.fc;
    target <= s.tgt;
    weight_index <= s.widx;
    weight_value <= s.wval;
    // busy only moves at a rising edge, so the falling-edge value holds for the next edge.
    do begin
      @(negedge clk);
      held = busy;
      @(posedge clk);
    end while (held);
  endtask

  function automatic logic [12:0] feature_value();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 13'(ONE);
    if (r < 10) return 13'($urandom_range(8191));
    if (r < 14) return 0;
    return 13'($urandom_range(ONE));
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int r;
    r = $urandom_range(99);
    s.op = (r < 45) ? CMD_TRAIN : (r < 72) ? CMD_INFER : (r < 95) ? CMD_LOAD : CMD_NONE;
    s.fa = feature_value();
    s.fb = feature_value();
    s.fc = feature_value();
    s.tgt = feature_value();
    s.widx = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(10));
    if ($urandom_range(5) == 0) s.wval = 16'($urandom);
    else s.wval = 16'($signed($urandom_range(16384)) - 8192);
    return s;
  endfunction

  task automatic directed();
    sample_t s;
    s = '{CMD_INFER, 0, 0, 0, 0, 0, 0};
    send(s);
    s.op = CMD_TRAIN;
    s.tgt = 13'(ONE);
    send(s);
    s.op = CMD_LOAD;
    for (int i = 0; i < 11; i++) begin
      s.widx = i;
      s.wval = (i % 2) ? 16'sh7fff : 16'sh8000;
      send(s);
    end
    s.widx = 4'd11;
    s.wval = 16'sh1234;
    send(s);
    s.widx = 4'd15;
    send(s);
    s = '{CMD_TRAIN, 13'h1fff, 13'h1fff, 13'h1fff, 13'h1fff, 0, 0};
    send(s);
    s = '{CMD_TRAIN, 13'(ONE), 0, 13'(ONE), 0, 0, 0};
    send(s);
    s = '{CMD_INFER, 13'(ONE), 13'(ONE), 13'(ONE), 0, 0, 0};
    send(s);
    s = '{CMD_NONE, 13'h1fff, 13'h1fff, 13'h1fff, 13'h1fff, 4'hf, 16'shffff};
    send(s);
    s = '{CMD_LOAD, 0, 0, 0, 0, 4'd8, 16'sd4096};
    send(s);
    s = '{CMD_TRAIN, 13'd2048, 13'd1000, 13'd3000, 13'd100, 0, 0};
    send(s);
    send(s);
  endtask

  task automatic run_phase(input int pct, input int count);
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      send(random_sample());
      if (n == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    sb = new();
    sb.init();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed();
    drain();
    reg_write(3'd0, 13'd0);
    reg_write(3'd4, 13'd0);
    run_phase(15, 380);
    reg_write(3'd0, 13'h1fff);
    reg_write(3'd4, 13'h1fff);
    run_phase(83, 380);
    reg_write(3'd0, 13'(ONE));
    reg_write(3'd4, 13'(ONE));
    run_phase(0, 190);
    reg_write(3'd0, 13'($urandom_range(800)));
    reg_write(3'd4, 13'($urandom_range(ONE)));
    run_phase(0, 190);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
